// ===== design/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared constants, request codes and control/status structs for the
// text terminal cell grid.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;
    localparam int TAB_STOP_DEF = 8;

    localparam logic [31:0] EMPTY_GLYPH = 32'h0000_0020;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam logic [3:0] REQ_PRINT = 4'd0;
    localparam logic [3:0] REQ_TAB   = 4'd1;
    localparam logic [3:0] REQ_CR    = 4'd2;
    localparam logic [3:0] REQ_UP    = 4'd3;
    localparam logic [3:0] REQ_DOWN  = 4'd4;
    localparam logic [3:0] REQ_LEFT  = 4'd5;
    localparam logic [3:0] REQ_RIGHT = 4'd6;
    localparam logic [3:0] REQ_BELL  = 4'd7;
    localparam logic [3:0] REQ_CLEOL = 4'd8;
    localparam logic [3:0] REQ_READ  = 4'd9;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_ATTR    = 2'd2;

    typedef struct packed {
        logic init_step;
        logic load;
        logic norm;
        logic exec;
        logic clr_step;
        logic read_cap;
        logic fin_load;
    } ttc_cmd_t;

    typedef struct packed {
        logic init_last;
        logic top_ok;
        logic go_clear;
        logic go_read;
        logic clr_last;
        logic out_free;
    } ttc_sts_t;

endpackage

// ===== design/ttc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttc_ctrl
// Sequencer: reset clearing pass, offset normalise, execute, clear sweep,
// read capture and result hand-off.
// ----------------------------------------------------------------------------
module ttc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ttc_pkg::ttc_sts_t sts,
    output ttc_pkg::ttc_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_NORM  = 7'b0000100,
        ST_EXEC  = 7'b0001000,
        ST_CLEAR = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  if (sts.init_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_NORM;
            ST_NORM:  if (sts.top_ok) state_next = ST_EXEC;
            ST_EXEC: begin
                priority if (sts.go_clear) state_next = ST_CLEAR;
                else if (sts.go_read)      state_next = ST_READ;
                else                       state_next = ST_FIN;
            end
            ST_CLEAR: if (sts.clr_last) state_next = ST_FIN;
            ST_READ:  state_next = ST_FIN;
            ST_FIN:   if (sts.out_free) state_next = ST_IDLE;
            default:  state_next = ST_INIT;
        endcase
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign cmd.init_step = (state_reg == ST_INIT);
    assign cmd.load      = s_tready && s_tvalid;
    assign cmd.norm      = (state_reg == ST_NORM);
    assign cmd.exec      = (state_reg == ST_EXEC);
    assign cmd.clr_step  = (state_reg == ST_CLEAR);
    assign cmd.read_cap  = (state_reg == ST_READ);
    assign cmd.fin_load  = (state_reg == ST_FIN) && sts.out_free;

    // clear sweep always ends in the result hand-off
    a_clr_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) && sts.clr_last |=> (state_reg == ST_FIN))
        else $error("clear sweep did not end in hand-off");

    a_read_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_FIN))
        else $error("read capture not followed by hand-off");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_NORM))
        else $error("accepted item did not start");

endmodule

// ===== design/ttc_datapath.sv =====
// ----------------------------------------------------------------------------
// ttc_datapath
// Cursor, row-offset ring, cell memory, clear sweep and result register.
// ----------------------------------------------------------------------------
module ttc_datapath #(
    parameter int MAX_COLS = ttc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ttc_pkg::MAX_ROWS_DEF,
    parameter int TAB_STOP = ttc_pkg::TAB_STOP_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ttc_pkg::ttc_cmd_t                  cmd,
    output ttc_pkg::ttc_sts_t                  sts,
    input  logic [7:0]                         cfg_columns,
    input  logic [6:0]                         cfg_rows,
    input  logic [15:0]                        cfg_attr,
    input  logic [3:0]                         in_req,
    input  logic [31:0]                        in_glyph,
    input  logic [5:0]                         in_read_row,
    input  logic [6:0]                         in_read_col,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [ttc_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    // effective screen size
    logic [CW:0] w_eff;
    logic [RW:0] h_eff;

    always_comb begin
        if (cfg_columns == 8'd0)                w_eff = (CW+1)'(1);
        else if (int'(cfg_columns) > MAX_COLS)  w_eff = (CW+1)'(MAX_COLS);
        else                                    w_eff = (CW+1)'(cfg_columns);
        if (cfg_rows == 7'd0)                   h_eff = (RW+1)'(1);
        else if (int'(cfg_rows) > MAX_ROWS)     h_eff = (RW+1)'(MAX_ROWS);
        else                                    h_eff = (RW+1)'(cfg_rows);
    end

    // item registers
    logic [3:0]  req_reg;
    logic [31:0] glyph_reg;
    logic [5:0]  rr_reg;
    logic [6:0]  rc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= in_req;
            glyph_reg <= in_glyph;
            rr_reg    <= in_read_row;
            rc_reg    <= in_read_col;
        end
    end

    // next tab stop per column, worked out at elaboration
    logic [CW:0] tab_next [MAX_COLS];
    for (genvar g = 0; g < MAX_COLS; g++) begin : g_tab
        assign tab_next[g] = (CW+1)'(g + TAB_STOP - (g % TAB_STOP));
    end

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg, top_reg;
    // working copy of the offset, reduced modulo the rows in use
    logic [RW-1:0] topm_reg;
    logic [CW-1:0] clr_col_reg, clr_end_reg;
    logic [RW-1:0] clr_row_reg;
    logic [AW-1:0] init_cnt_reg;

    logic [CW:0] col1;
    logic [RW:0] row1, top1, cur_sum, rd_sum;
    logic        wrap, last_row, rd_ok;
    logic [RW-1:0] cur_phys, rd_phys;

    assign col1     = {1'b0, col_reg} + (CW+1)'(1);
    assign row1     = {1'b0, row_reg} + (RW+1)'(1);
    assign top1     = {1'b0, topm_reg} + (RW+1)'(1);
    assign wrap     = (col1 >= w_eff);
    assign last_row = (row1 >= h_eff);
    assign cur_sum  = {1'b0, topm_reg} + {1'b0, row_reg};
    assign cur_phys = (cur_sum >= h_eff) ? RW'(cur_sum - h_eff) : RW'(cur_sum);
    assign rd_sum   = {1'b0, topm_reg} + (RW+1)'(rr_reg);
    assign rd_phys  = (rd_sum >= h_eff) ? RW'(rd_sum - h_eff) : RW'(rd_sum);
    assign rd_ok    = (int'(rr_reg) < int'(h_eff)) && (int'(rc_reg) < int'(w_eff));

    assign sts.top_ok    = ({1'b0, topm_reg} < h_eff);
    assign sts.init_last = (init_cnt_reg == AW'(DEPTH - 1));
    assign sts.clr_last  = (clr_col_reg == clr_end_reg);
    assign sts.go_read   = (req_reg == ttc_pkg::REQ_READ);
    assign sts.go_clear  = (req_reg == ttc_pkg::REQ_CLEOL) ||
                           ((req_reg == ttc_pkg::REQ_PRINT) && wrap && last_row);
    assign sts.out_free  = !m_tvalid || m_tready;

    // cursor, offset and sweep bounds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            top_reg      <= '0;
            topm_reg     <= '0;
            init_cnt_reg <= '0;
        end else begin
            if (cmd.init_step) init_cnt_reg <= init_cnt_reg + AW'(1);
            if (cmd.load) topm_reg <= top_reg;
            if (cmd.norm) begin
                if (!sts.top_ok) topm_reg <= RW'({1'b0, topm_reg} - h_eff);
                if ({1'b0, col_reg} > w_eff - (CW+1)'(1)) col_reg <= CW'(w_eff - (CW+1)'(1));
                if ({1'b0, row_reg} > h_eff - (RW+1)'(1)) row_reg <= RW'(h_eff - (RW+1)'(1));
            end
            if (cmd.exec) begin
                unique case (req_reg)
                    ttc_pkg::REQ_PRINT: begin
                        if (wrap) begin
                            col_reg <= '0;
                            if (last_row) top_reg <= (top1 >= h_eff) ? '0 : RW'(top1);
                            else          row_reg <= RW'(row1);
                        end else begin
                            col_reg <= CW'(col1);
                        end
                    end
                    ttc_pkg::REQ_TAB:
                        if (int'(col_reg) + TAB_STOP < int'(w_eff))
                            col_reg <= CW'(tab_next[col_reg]);
                    ttc_pkg::REQ_CR:    col_reg <= '0;
                    ttc_pkg::REQ_UP:    if (row_reg != '0) row_reg <= row_reg - RW'(1);
                    ttc_pkg::REQ_DOWN:  if (!last_row) row_reg <= RW'(row1);
                    ttc_pkg::REQ_LEFT:  if (col_reg != '0) col_reg <= col_reg - CW'(1);
                    ttc_pkg::REQ_RIGHT: if (!wrap) col_reg <= CW'(col1);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (req_reg == ttc_pkg::REQ_CLEOL) begin
                clr_row_reg <= cur_phys;
                clr_col_reg <= col_reg;
                clr_end_reg <= CW'(w_eff - (CW+1)'(1));
            end else begin
                // scroll: the freed bottom row is the old top row
                clr_row_reg <= topm_reg;
                clr_col_reg <= '0;
                clr_end_reg <= CW'(MAX_COLS - 1);
            end
        end else if (cmd.clr_step) begin
            clr_col_reg <= clr_col_reg + CW'(1);
        end
    end

    // cell memory: {attr, glyph}
    logic [47:0]   mem [DEPTH];
    logic [47:0]   mem_q;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [47:0]   mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = init_cnt_reg;
        mem_wdata = {16'h0000, ttc_pkg::EMPTY_GLYPH};
        priority if (cmd.init_step) begin
            mem_we = 1'b1;
        end else if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(int'(clr_row_reg) * MAX_COLS + int'(clr_col_reg));
        end else if (cmd.exec && (req_reg == ttc_pkg::REQ_PRINT)) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(int'(cur_phys) * MAX_COLS + int'(col_reg));
            mem_wdata = {cfg_attr, glyph_reg};
        end
    end

    assign mem_raddr = AW'(int'(rd_phys) * MAX_COLS + int'(CW'(rc_reg)));

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (cmd.exec) mem_q <= mem[mem_raddr];
    end

    // pending result fields
    logic        p_written_reg, p_redraw_reg, p_cleared_reg, p_bell_reg, rd_ok_reg;
    logic [6:0]  p_wcol_reg;
    logic [5:0]  p_wrow_reg;
    logic [31:0] p_rglyph_reg;
    logic [15:0] p_rattr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            p_written_reg <= (req_reg == ttc_pkg::REQ_PRINT);
            p_wcol_reg    <= (req_reg == ttc_pkg::REQ_PRINT) ? 7'(col_reg) : 7'd0;
            p_wrow_reg    <= (req_reg == ttc_pkg::REQ_PRINT) ? 6'(row_reg) : 6'd0;
            p_redraw_reg  <= (req_reg == ttc_pkg::REQ_PRINT) && wrap && last_row;
            p_cleared_reg <= (req_reg == ttc_pkg::REQ_CLEOL);
            p_bell_reg    <= (req_reg == ttc_pkg::REQ_BELL);
            rd_ok_reg     <= rd_ok;
            p_rglyph_reg  <= '0;
            p_rattr_reg   <= '0;
        end else if (cmd.read_cap && rd_ok_reg) begin
            p_rglyph_reg <= mem_q[31:0];
            p_rattr_reg  <= mem_q[47:32];
        end
    end

    // result register
    logic                           m_tvalid_reg;
    logic [ttc_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.fin_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_load) begin
            m_tdata_reg <= {2'b00, p_rattr_reg, p_rglyph_reg, p_bell_reg, p_cleared_reg,
                            p_redraw_reg, p_wrow_reg, p_wcol_reg, p_written_reg,
                            6'(row_reg), 7'(col_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_top_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> ({1'b0, topm_reg} < h_eff))
        else $error("row offset not normalised at execute");

    a_cursor_in: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> ({1'b0, col_reg} < w_eff) && ({1'b0, row_reg} < h_eff))
        else $error("cursor outside screen at execute");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> (clr_col_reg <= clr_end_reg))
        else $error("clear sweep ran past its end");

endmodule

// ===== design/text_terminal_cell_grid_unit.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cell_grid_unit
// Character-cell terminal screen with cursor and row-offset scrolling.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | one terminal command item
//  m_       | out       | one result item per command
//  APB      | in/out    | columns, rows, current_attr registers
//
//  Steps: accept, then normalise (repeated while the row offset is not
//  below the rows in use after a rows change), execute, hand-off. Read
//  adds a capture from the registered memory port; a line clear writes
//  each cleared cell in turn, a scroll every cell of the freed row (single
//  write port of the memory). A clearing pass over all MAX_ROWS*MAX_COLS
//  cells runs after reset, ahead of any item; APB writes are taken throughout.
//  A result waits in the output register; the next item may still be taken
//  and run, but holds in hand-off (s_tready low) until that register frees.
// ----------------------------------------------------------------------------
module text_terminal_cell_grid_unit #(
    parameter int MAX_COLS = ttc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ttc_pkg::MAX_ROWS_DEF,
    parameter int TAB_STOP = ttc_pkg::TAB_STOP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [ttc_pkg::IN_DATA_W-1:0] s_tdata,  // glyph, read_row, read_col, pad
    input  logic [3:0]  s_tuser,                    // req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // cursor_col, cursor_row, cell_written, written_col, written_row,
    // full_redraw, row_cleared, bell_ring, read_glyph, read_attr, pad
    output logic [ttc_pkg::OUT_DATA_W-1:0] m_tdata
);

    // configuration registers
    logic [7:0]  columns_reg;
    logic [6:0]  rows_reg;
    logic [15:0] attr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= 8'd80;
            rows_reg    <= 7'd25;
            attr_reg    <= 16'h0000;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                ttc_pkg::REG_COLUMNS: columns_reg <= pwdata[7:0];
                ttc_pkg::REG_ROWS:    rows_reg    <= pwdata[6:0];
                ttc_pkg::REG_ATTR:    attr_reg    <= pwdata[15:0];
                default: ;  // no register there
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ttc_pkg::REG_COLUMNS: prdata = {24'h0, columns_reg};
            ttc_pkg::REG_ROWS:    prdata = {25'h0, rows_reg};
            ttc_pkg::REG_ATTR:    prdata = {16'h0, attr_reg};
            default:              prdata = 32'h0;
        endcase
    end

    ttc_pkg::ttc_cmd_t cmd;
    ttc_pkg::ttc_sts_t sts;

    ttc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_columns (columns_reg),
        .cfg_rows    (rows_reg),
        .cfg_attr    (attr_reg),
        .in_req      (s_tuser),
        .in_glyph    (s_tdata[31:0]),
        .in_read_row (s_tdata[37:32]),
        .in_read_col (s_tdata[44:38]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule
